// File: rtl/stq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and codes of the sorted timer queue.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int SLOT_W  = 5;
  localparam int OWNER_W = 8;
  localparam int DATA_W  = 32;
  localparam int MODE_W  = 3;
  localparam int KIND_W  = 2;

  localparam logic [DATA_W-1:0] COUNT_MAX = 32'hffff_fffe;

  // input mode codes
  localparam logic [MODE_W-1:0] MODE_ALLOC  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FREE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INIT   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SET    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CANCEL = 3'd4;
  localparam logic [MODE_W-1:0] MODE_TICK   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_CALL   = 3'd6;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_DONE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXPIRY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

  // slot status codes
  localparam logic [1:0] ST_FREE  = 2'd0;
  localparam logic [1:0] ST_ALLOC = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  // config register indexes
  localparam logic REG_TASK_SLOT = 1'b0;
  localparam logic REG_TASK_EN   = 1'b1;

  localparam int FIFO_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_ALLOC  = 3'd0,
    OP_FREE   = 3'd1,
    OP_INIT   = 3'd2,
    OP_SET    = 3'd3,
    OP_CANCEL = 3'd4,
    OP_TICK   = 3'd5,
    OP_CALL   = 3'd6,
    OP_NOP    = 3'd7
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic [SLOT_W-1:0]        slot;
    logic [OWNER_W-1:0]       owner;
    logic signed [DATA_W-1:0] payload;
    logic                     mark;
    logic [DATA_W-1:0]        delay;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic                     ok;
    logic [SLOT_W-1:0]        slot;
    logic [OWNER_W-1:0]       owner;
    logic signed [DATA_W-1:0] payload;
    logic                     sw_req;
    logic                     last;
  } res_t;

endpackage
`default_nettype wire

// File: rtl/sorted_software_timer_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_software_timer_queue
// Timer pool with a deadline-sorted list and a saturating tick count.
// ----------------------------------------------------------------------------
// Commands go through a two-entry queue to a sequencer that owns the slot
// pool and the linked list. Allocate, init, and free or cancel of a slot not
// running go from execute straight to emit. Removing a running slot walks
// the list from its head, one entry a cycle; a settime then walks again to
// insert, via a read and a compare state per entry passed. Cancel-all visits
// every slot in turn, with a walk for each running match. A tick bumps the
// count, then takes expired timers off the head. Results leave through one
// output register, so the sequencer stalls only while a result is not taken.
module sorted_software_timer_queue import stq_pkg::*; #(
  parameter int SLOTS = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [MODE_W-1:0]        in_mode,
  input  wire logic [SLOT_W-1:0]        in_slot,
  input  wire logic [OWNER_W-1:0]       in_owner,
  input  wire logic signed [DATA_W-1:0] in_payload,
  input  wire logic                     in_auto_cancel,
  input  wire logic [DATA_W-1:0]        in_delay,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [KIND_W-1:0]             out_kind,
  output logic                          out_ok,
  output logic [SLOT_W-1:0]             out_slot,
  output logic [OWNER_W-1:0]            out_owner,
  output logic signed [DATA_W-1:0]      out_payload,
  output logic                          out_sw_req,
  output logic                          out_last,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [2:0]               paddr,
  input  wire logic [31:0]              pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic              push, fifo_full, pop, fifo_valid;
  cmd_t              push_data, fifo_data;
  res_t              res;
  logic [SLOT_W-1:0] task_slot_r;
  logic              task_en_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_slot_r <= '0;
      task_en_r   <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_TASK_SLOT: task_slot_r <= pwdata[SLOT_W-1:0];
        REG_TASK_EN:   task_en_r   <= pwdata[0];
        default:       task_en_r   <= task_en_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TASK_SLOT: prdata = {{(32 - SLOT_W){1'b0}}, task_slot_r};
      REG_TASK_EN:   prdata = {31'd0, task_en_r};
      default:       prdata = '0;
    endcase
  end

  stq_front #(.SLOTS(SLOTS)) u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_slot        (in_slot),
    .in_owner       (in_owner),
    .in_payload     (in_payload),
    .in_auto_cancel (in_auto_cancel),
    .in_delay       (in_delay),
    .push           (push),
    .push_data      (push_data),
    .fifo_full      (fifo_full)
  );

  stq_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop       (pop),
    .not_empty (fifo_valid),
    .pop_data  (fifo_data)
  );

  stq_back #(.SLOTS(SLOTS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_valid (fifo_valid),
    .fifo_data  (fifo_data),
    .pop        (pop),
    .task_slot  (task_slot_r),
    .task_en    (task_en_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (res)
  );

  assign out_kind    = res.kind;
  assign out_ok      = res.ok;
  assign out_slot    = res.slot;
  assign out_owner   = res.owner;
  assign out_payload = res.payload;
  assign out_sw_req  = res.sw_req;
  assign out_last    = res.last;

endmodule
`default_nettype wire

// File: rtl/stq_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stq_front
// Takes input beats and decodes them into queue commands.
// ----------------------------------------------------------------------------
module stq_front import stq_pkg::*; #(
  parameter int SLOTS = 32
) (
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [MODE_W-1:0]        in_mode,
  input  wire logic [SLOT_W-1:0]        in_slot,
  input  wire logic [OWNER_W-1:0]       in_owner,
  input  wire logic signed [DATA_W-1:0] in_payload,
  input  wire logic                     in_auto_cancel,
  input  wire logic [DATA_W-1:0]        in_delay,
  output logic                          push,
  output cmd_t                          push_data,
  input  wire logic                     fifo_full
);

  logic inr;

  assign inr      = ({1'b0, in_slot} < (SLOT_W + 1)'(SLOTS));
  assign in_ready = !fifo_full;
  assign push     = in_valid && !fifo_full;

  always_comb begin
    push_data.slot    = in_slot;
    push_data.owner   = in_owner;
    push_data.payload = in_payload;
    push_data.mark    = in_auto_cancel;
    push_data.delay   = in_delay;
    case (in_mode)
      MODE_ALLOC:  push_data.op = OP_ALLOC;
      MODE_FREE:   push_data.op = inr ? OP_FREE : OP_NOP;
      MODE_INIT:   push_data.op = inr ? OP_INIT : OP_NOP;
      MODE_SET:    push_data.op = inr ? OP_SET : OP_NOP;
      MODE_CANCEL: push_data.op = inr ? OP_CANCEL : OP_NOP;
      MODE_TICK:   push_data.op = OP_TICK;
      MODE_CALL:   push_data.op = OP_CALL;
      default:     push_data.op = OP_NOP;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/stq_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stq_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module stq_fifo import stq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_data,
  output logic      full,
  input  wire logic pop,
  output logic      not_empty,
  output cmd_t      pop_data
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  cmd_t          mem_r [FIFO_DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CW'(FIFO_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = (push && wp_r == PW'(FIFO_DEPTH - 1)) ? '0 : wp_r + PW'(push);
    rp_nxt  = (pop && rp_r == PW'(FIFO_DEPTH - 1)) ? '0 : rp_r + PW'(pop);
    cnt_nxt = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// File: rtl/stq_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stq_back
// Executes commands on the slot pool and the deadline-sorted list.
// ----------------------------------------------------------------------------
module stq_back import stq_pkg::*; #(
  parameter int SLOTS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              fifo_valid,
  input  wire cmd_t              fifo_data,
  output logic                   pop,
  input  wire logic [SLOT_W-1:0] task_slot,
  input  wire logic              task_en,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output res_t                   out_data
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LW = $clog2(SLOTS + 1);
  localparam logic [LW-1:0] NIL = LW'(SLOTS);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_EXEC = 13'b0000000000010,
    S_UNL0 = 13'b0000000000100,
    S_UNLW = 13'b0000000001000,
    S_POST = 13'b0000000010000,
    S_INS0 = 13'b0000000100000,
    S_INSW = 13'b0000001000000,
    S_INSC = 13'b0000010000000,
    S_INSF = 13'b0000100000000,
    S_CALL = 13'b0001000000000,
    S_EXP  = 13'b0010000000000,
    S_EMIT = 13'b0100000000000,
    S_SPARE = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  cmd_t   cmd_r, cmd_nxt;
  res_t   res_r, res_nxt, pend_r, pend_nxt, out_r, emit_data;
  logic   out_valid_r, pend_v_r, pend_v_nxt, emit_go, can_emit;

  logic [IW-1:0]     u_r, u_nxt, p_r, p_nxt;
  logic [LW-1:0]     lu_r, lu_nxt, n_r, n_nxt, head_r, head_nxt, i_r, i_nxt;
  logic [DATA_W-1:0] d_r, d_nxt, cnt_r, cnt_nxt;

  // slot pool
  logic [1:0]               status_r [SLOTS];
  logic                     mark_r   [SLOTS];
  logic [OWNER_W-1:0]       owner_r  [SLOTS];
  logic signed [DATA_W-1:0] pay_r    [SLOTS];
  logic [DATA_W-1:0]        dl_r     [SLOTS];
  logic [LW-1:0]            link_r   [SLOTS];

  logic [IW-1:0] la, da, oa, sa, st_wa, lk_wa, alloc_idx, s_idx, head_idx;
  logic [LW-1:0] link_rd, lk_wd;
  logic [DATA_W-1:0] dl_rd;
  logic [1:0]    st_rd, st_wd;
  logic          st_we, lk_we, dl_we, init_we, mark_clr, any_free, expire;

  assign s_idx    = cmd_r.slot[IW-1:0];
  assign head_idx = head_r[IW-1:0];
  assign link_rd  = link_r[la];
  assign dl_rd    = dl_r[da];
  assign st_rd    = status_r[sa];
  assign can_emit = !out_valid_r || out_ready;
  assign expire   = (head_r < NIL) && (dl_rd <= cnt_r);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // lowest free slot
  always_comb begin
    any_free  = 1'b0;
    alloc_idx = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (status_r[k] == ST_FREE) begin
        any_free  = 1'b1;
        alloc_idx = IW'(k);
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    res_nxt    = res_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    u_nxt      = u_r;
    p_nxt      = p_r;
    lu_nxt     = lu_r;
    n_nxt      = n_r;
    head_nxt   = head_r;
    i_nxt      = i_r;
    d_nxt      = d_r;
    cnt_nxt    = cnt_r;
    pop        = 1'b0;
    emit_go    = 1'b0;
    emit_data  = res_r;
    st_we      = 1'b0;
    st_wa      = s_idx;
    st_wd      = ST_FREE;
    lk_we      = 1'b0;
    lk_wa      = p_r;
    lk_wd      = n_r;
    dl_we      = 1'b0;
    init_we    = 1'b0;
    mark_clr   = 1'b0;
    la         = u_r;
    da         = head_idx;
    oa         = head_idx;
    sa         = s_idx;
    case (state_r)
      S_IDLE: begin
        if (fifo_valid) begin
          pop       = 1'b1;
          cmd_nxt   = fifo_data;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_nxt      = '0;
        res_nxt.kind = KIND_DONE;
        res_nxt.last = 1'b1;
        u_nxt        = s_idx;
        state_nxt    = S_EMIT;
        case (cmd_r.op)
          OP_ALLOC: begin
            if (any_free) begin
              st_we       = 1'b1;
              st_wa       = alloc_idx;
              st_wd       = ST_ALLOC;
              mark_clr    = 1'b1;
              res_nxt.ok  = 1'b1;
              res_nxt.slot = SLOT_W'(alloc_idx);
            end
          end
          OP_FREE: begin
            if (st_rd == ST_RUN) begin
              state_nxt = S_UNL0;
            end else begin
              st_we = 1'b1;
            end
          end
          OP_INIT: init_we = 1'b1;
          OP_SET: begin
            if (st_rd != ST_FREE) begin
              d_nxt = cmd_r.delay + cnt_r;
              dl_we = 1'b1;
              st_we = 1'b1;
              st_wd = ST_RUN;
              state_nxt = (st_rd == ST_RUN) ? S_UNL0 : S_INS0;
            end
          end
          OP_CANCEL: begin
            if (st_rd == ST_RUN) begin
              st_we      = 1'b1;
              st_wd      = ST_ALLOC;
              res_nxt.ok = 1'b1;
              state_nxt  = S_UNL0;
            end
          end
          OP_TICK: begin
            cnt_nxt    = (cnt_r < COUNT_MAX) ? cnt_r + DATA_W'(1) : cnt_r;
            pend_v_nxt = 1'b0;
            state_nxt  = S_EXP;
          end
          OP_CALL: begin
            i_nxt     = '0;
            state_nxt = S_CALL;
          end
          default: state_nxt = S_EMIT;
        endcase
      end
      S_UNL0: begin
        la = u_r;
        if (head_r == LW'(u_r)) begin
          head_nxt  = link_rd;
          state_nxt = S_POST;
        end else begin
          lu_nxt    = link_rd;
          p_nxt     = head_idx;
          state_nxt = S_UNLW;
        end
      end
      S_UNLW: begin
        // walk to the predecessor of the slot being removed
        la = p_r;
        if (link_rd == LW'(u_r)) begin
          lk_we     = 1'b1;
          lk_wa     = p_r;
          lk_wd     = lu_r;
          state_nxt = S_POST;
        end else if (link_rd >= NIL) begin
          state_nxt = S_POST;
        end else begin
          p_nxt = link_rd[IW-1:0];
        end
      end
      S_POST: begin
        state_nxt = S_EMIT;
        case (cmd_r.op)
          OP_FREE: begin
            st_we = 1'b1;
            st_wa = u_r;
          end
          OP_SET: state_nxt = S_INS0;
          OP_CALL: begin
            st_we     = 1'b1;
            st_wa     = u_r;
            i_nxt     = i_r + LW'(1);
            state_nxt = S_CALL;
          end
          default: state_nxt = S_EMIT;
        endcase
      end
      S_INS0: begin
        da = head_idx;
        if (head_r >= NIL || d_r <= dl_rd) begin
          lk_we     = 1'b1;
          lk_wa     = u_r;
          lk_wd     = head_r;
          head_nxt  = LW'(u_r);
          state_nxt = S_EMIT;
        end else begin
          p_nxt     = head_idx;
          state_nxt = S_INSW;
        end
      end
      S_INSW: begin
        la        = p_r;
        n_nxt     = link_rd;
        state_nxt = S_INSC;
      end
      S_INSC: begin
        // new entry goes ahead of equal deadlines
        da = n_r[IW-1:0];
        if (n_r >= NIL || d_r <= dl_rd) begin
          lk_we     = 1'b1;
          lk_wa     = p_r;
          lk_wd     = LW'(u_r);
          state_nxt = S_INSF;
        end else begin
          p_nxt     = n_r[IW-1:0];
          state_nxt = S_INSW;
        end
      end
      S_INSF: begin
        lk_we     = 1'b1;
        lk_wa     = u_r;
        lk_wd     = n_r;
        state_nxt = S_EMIT;
      end
      S_CALL: begin
        sa = i_r[IW-1:0];
        oa = i_r[IW-1:0];
        if (i_r == NIL) begin
          state_nxt = S_EMIT;
        end else if (st_rd != ST_FREE && mark_r[oa] && owner_r[oa] == cmd_r.owner) begin
          if (st_rd == ST_RUN) begin
            u_nxt     = i_r[IW-1:0];
            state_nxt = S_UNL0;
          end else begin
            st_we = 1'b1;
            st_wa = i_r[IW-1:0];
            i_nxt = i_r + LW'(1);
          end
        end else begin
          i_nxt = i_r + LW'(1);
        end
      end
      S_EXP: begin
        // one expiry is held back until the next head shows whether it is last
        la = head_idx;
        da = head_idx;
        oa = head_idx;
        if (expire) begin
          if (!pend_v_r || can_emit) begin
            if (pend_v_r) begin
              emit_go   = 1'b1;
              emit_data = pend_r;
            end
            pend_nxt         = '0;
            pend_nxt.kind    = KIND_EXPIRY;
            pend_nxt.slot    = SLOT_W'(head_idx);
            pend_nxt.owner   = owner_r[oa];
            pend_nxt.payload = pay_r[oa];
            pend_nxt.sw_req  = task_en && (SLOT_W'(head_idx) == task_slot);
            pend_v_nxt       = 1'b1;
            st_we            = 1'b1;
            st_wa            = head_idx;
            st_wd            = ST_ALLOC;
            head_nxt         = link_rd;
          end
        end else if (can_emit) begin
          emit_go = 1'b1;
          if (pend_v_r) begin
            emit_data      = pend_r;
            emit_data.last = 1'b1;
          end else begin
            emit_data      = '0;
            emit_data.kind = KIND_EMPTY;
            emit_data.last = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (can_emit) begin
          emit_go   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      head_r      <= NIL;
      cnt_r       <= '0;
      for (int k = 0; k < SLOTS; k++) begin
        status_r[k] <= ST_FREE;
      end
    end else begin
      state_r  <= state_nxt;
      pend_v_r <= pend_v_nxt;
      head_r   <= head_nxt;
      cnt_r    <= cnt_nxt;
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (st_we) begin
        status_r[st_wa] <= st_wd;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    res_r  <= res_nxt;
    pend_r <= pend_nxt;
    u_r    <= u_nxt;
    p_r    <= p_nxt;
    lu_r   <= lu_nxt;
    n_r    <= n_nxt;
    i_r    <= i_nxt;
    d_r    <= d_nxt;
    if (emit_go) begin
      out_r <= emit_data;
    end
    if (lk_we) begin
      link_r[lk_wa] <= lk_wd;
    end
    if (dl_we) begin
      dl_r[s_idx] <= d_nxt;
    end
    if (init_we) begin
      owner_r[s_idx] <= cmd_r.owner;
      pay_r[s_idx]   <= cmd_r.payload;
    end
    if (init_we) begin
      mark_r[s_idx] <= cmd_r.mark;
    end else if (mark_clr) begin
      mark_r[alloc_idx] <= 1'b0;
    end
  end

endmodule
`default_nettype wire
